/* rtl/mts_pkg.sv */
package mts_pkg;

  localparam int UnitMsW    = 10;
  localparam int FreqW      = 15;
  localparam int UnitsW     = 4;
  localparam int DurW       = 14;
  localparam int PatW       = 8;
  localparam int CharW      = 8;
  localparam int KindW      = 2;
  localparam int CfgIndexW  = 3;
  localparam int CfgDataW   = 15;
  localparam int MulCntW    = 2;

  localparam logic [KindW-1:0] KIND_TONE = 2'd0;
  localparam logic [KindW-1:0] KIND_REST = 2'd1;
  localparam logic [KindW-1:0] KIND_STOP = 2'd2;

  localparam logic [CfgIndexW-1:0] REG_UNIT_MS    = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_TONE_FREQ  = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_DOT_UNITS  = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_DASH_UNITS = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_SYM_GAP    = 3'd4;
  localparam logic [CfgIndexW-1:0] REG_LETTER_GAP = 3'd5;
  localparam logic [CfgIndexW-1:0] REG_WORD_GAP   = 3'd6;

  localparam logic [UnitMsW-1:0] UNIT_MS_RESET    = 10'd50;
  localparam logic [FreqW-1:0]   TONE_FREQ_RESET  = 15'd440;
  localparam logic [UnitsW-1:0]  DOT_RESET        = 4'd1;
  localparam logic [UnitsW-1:0]  DASH_RESET       = 4'd3;
  localparam logic [UnitsW-1:0]  SYM_GAP_RESET    = 4'd1;
  localparam logic [UnitsW-1:0]  LETTER_GAP_RESET = 4'd3;
  localparam logic [UnitsW-1:0]  WORD_GAP_RESET   = 4'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PICK,
    ST_MUL,
    ST_LOAD
  } state_t;

  function automatic logic is_blank(input logic [CharW-1:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [CharW-1:0] fold_lower(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end else if (c >= 8'hC0 && c <= 8'hDE && c != 8'hD7) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // Patterns are read from the LSB up to a marker 1; a 1 bit is a dot.
  function automatic logic [PatW-1:0] morse_pattern(input logic [CharW-1:0] c);
    logic [PatW-1:0] p;
    unique case (c)
      8'h61: p = 8'h05;
      8'h62: p = 8'h1E;
      8'h63: p = 8'h1A;
      8'h64: p = 8'h0E;
      8'h65: p = 8'h03;
      8'h66: p = 8'h1B;
      8'h67: p = 8'h0C;
      8'h68: p = 8'h1F;
      8'h69: p = 8'h07;
      8'h6A: p = 8'h11;
      8'h6B: p = 8'h0A;
      8'h6C: p = 8'h1D;
      8'h6D: p = 8'h04;
      8'h6E: p = 8'h06;
      8'h6F: p = 8'h08;
      8'h70: p = 8'h19;
      8'h71: p = 8'h14;
      8'h72: p = 8'h0D;
      8'h73: p = 8'h0F;
      8'h74: p = 8'h02;
      8'h75: p = 8'h0B;
      8'h76: p = 8'h17;
      8'h77: p = 8'h09;
      8'h78: p = 8'h16;
      8'h79: p = 8'h12;
      8'h7A: p = 8'h1C;
      8'hE4: p = 8'h15;
      8'hE1: p = 8'h29;
      8'hE5: p = 8'h29;
      8'hE9: p = 8'h3B;
      8'hF1: p = 8'h24;
      8'hF6: p = 8'h18;
      8'hFC: p = 8'h13;
      8'h30: p = 8'h20;
      8'h31: p = 8'h21;
      8'h32: p = 8'h23;
      8'h33: p = 8'h27;
      8'h34: p = 8'h2F;
      8'h35: p = 8'h3F;
      8'h36: p = 8'h3E;
      8'h37: p = 8'h3C;
      8'h38: p = 8'h38;
      8'h39: p = 8'h30;
      8'h2E: p = 8'h55;
      8'h2C: p = 8'h4C;
      8'h3F: p = 8'h73;
      8'h21: p = 8'h4A;
      8'h3A: p = 8'h78;
      8'h27: p = 8'h61;
      8'h22: p = 8'h6D;
      8'h28: p = 8'h32;
      8'h29: p = 8'h52;
      8'h3D: p = 8'h2E;
      8'h2B: p = 8'h35;
      8'h2D: p = 8'h5E;
      8'h2F: p = 8'h36;
      8'h26: p = 8'h3D;
      8'h40: p = 8'h69;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

endpackage

/* rtl/morse_tone_sequencer.sv */
// Channel   Direction  Handshake            Payload
// in        input      in_valid, in_stall   func, code_point
// out       output     out_valid, out_stall element_kind, duration_ms, frequency_hz, last
// cfg       input      cfg_we               cfg_index, cfg_data
//
// Each element passes through a select step (ST_PICK), then the bit-serial
// shift-and-add multiplier that forms the duration (ST_MUL), then a load of the output register (ST_LOAD).
// An item yields up to twelve elements.
// Reset (rst, synchronous) restores the default registers and the after-space flag.
// A stalled output holds the sequencer in its load step; a new item is taken
// while the last element of the previous one still waits in the output register.
module morse_tone_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            func,
  input  logic [mts_pkg::CharW-1:0]       code_point,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mts_pkg::KindW-1:0]       element_kind,
  output logic [mts_pkg::DurW-1:0]        duration_ms,
  output logic [mts_pkg::FreqW-1:0]       frequency_hz,
  output logic                            last,
  input  logic                            cfg_we,
  input  logic [mts_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [mts_pkg::CfgDataW-1:0]    cfg_data
);
  import mts_pkg::*;

  logic [UnitMsW-1:0] unit_ms;
  logic [FreqW-1:0]   tone_freq;
  logic [UnitsW-1:0]  dot_units;
  logic [UnitsW-1:0]  dash_units;
  logic [UnitsW-1:0]  sym_gap_units;
  logic [UnitsW-1:0]  letter_gap_units;
  logic [UnitsW-1:0]  word_gap_units;

  state_t state;
  state_t state_next;

  logic              after_space;
  logic              stop_pend;
  logic              lead_pend;
  logic [UnitsW-1:0] lead_units;
  logic [PatW-1:0]   pat;
  logic              sep;

  logic [KindW-1:0]   cur_kind;
  logic               cur_last;
  logic [UnitsW-1:0]  mul_units;
  logic [DurW-1:0]    mcand;
  logic [DurW-1:0]    acc;
  logic [MulCntW-1:0] mul_cnt;

  logic              in_take;
  logic              load_ok;
  logic              pick_valid;
  logic [KindW-1:0]  pick_kind;
  logic [UnitsW-1:0] pick_units;
  logic              pick_last;
  logic              pat_more;
  logic [CharW-1:0]  folded;

  assign folded   = fold_lower(code_point);
  assign pat_more = (pat[PatW-1:1] != '0);
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ms          <= UNIT_MS_RESET;
      tone_freq        <= TONE_FREQ_RESET;
      dot_units        <= DOT_RESET;
      dash_units       <= DASH_RESET;
      sym_gap_units    <= SYM_GAP_RESET;
      letter_gap_units <= LETTER_GAP_RESET;
      word_gap_units   <= WORD_GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_UNIT_MS:    unit_ms          <= cfg_data[UnitMsW-1:0];
        REG_TONE_FREQ:  tone_freq        <= cfg_data[FreqW-1:0];
        REG_DOT_UNITS:  dot_units        <= cfg_data[UnitsW-1:0];
        REG_DASH_UNITS: dash_units       <= cfg_data[UnitsW-1:0];
        REG_SYM_GAP:    sym_gap_units    <= cfg_data[UnitsW-1:0];
        REG_LETTER_GAP: letter_gap_units <= cfg_data[UnitsW-1:0];
        REG_WORD_GAP:   word_gap_units   <= cfg_data[UnitsW-1:0];
        default: ;
      endcase
    end
  end

  // Element selection: stop, then the leading gap, then marks with symbol gaps between.
  always_comb begin
    pick_valid = 1'b1;
    pick_kind  = KIND_REST;
    pick_units = '0;
    pick_last  = 1'b0;
    priority if (stop_pend) begin
      pick_kind = KIND_STOP;
      pick_last = 1'b1;
    end else if (lead_pend) begin
      pick_units = lead_units;
      pick_last  = !pat_more;
    end else if (pat_more) begin
      if (sep) begin
        pick_units = sym_gap_units;
      end else begin
        pick_kind  = KIND_TONE;
        pick_units = pat[0] ? dot_units : dash_units;
        pick_last  = (pat[PatW-1:1] == 7'd1);
      end
    end else begin
      pick_valid = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_PICK;
      ST_PICK: state_next = pick_valid ? ST_MUL : ST_IDLE;
      ST_MUL:  if (mul_cnt == '1) state_next = ST_LOAD;
      ST_LOAD: if (load_ok) state_next = ST_PICK;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    load_ok  = (state == ST_LOAD) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      after_space <= 1'b1;
      stop_pend   <= 1'b0;
      lead_pend   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (in_take) begin
        if (func) begin
          stop_pend <= 1'b1;
          lead_pend <= 1'b0;
        end else if (is_blank(code_point)) begin
          stop_pend   <= 1'b0;
          lead_pend   <= !after_space;
          after_space <= 1'b1;
        end else begin
          stop_pend   <= 1'b0;
          lead_pend   <= !after_space;
          after_space <= 1'b0;
        end
      end else if (state == ST_PICK) begin
        priority if (stop_pend) begin
          stop_pend <= 1'b0;
        end else if (lead_pend) begin
          lead_pend <= 1'b0;
        end else begin
        end
      end
      if (load_ok) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      sep        <= 1'b0;
      lead_units <= is_blank(code_point) ? word_gap_units : letter_gap_units;
      pat        <= (func || is_blank(code_point)) ? '0 : morse_pattern(folded);
    end else if (state == ST_PICK) begin
      if (!stop_pend && !lead_pend && pat_more) begin
        if (sep) begin
          sep <= 1'b0;
        end else begin
          sep <= 1'b1;
          pat <= pat >> 1;
        end
      end
      cur_kind  <= pick_kind;
      cur_last  <= pick_last;
      mul_units <= pick_units;
      mcand     <= DurW'(unit_ms);
      acc       <= '0;
      mul_cnt   <= '0;
    end else if (state == ST_MUL) begin
      acc       <= acc + (mul_units[0] ? mcand : '0);
      mcand     <= mcand << 1;
      mul_units <= mul_units >> 1;
      mul_cnt   <= mul_cnt + 1'b1;
    end
    if (load_ok) begin
      element_kind <= cur_kind;
      duration_ms  <= acc;
      frequency_hz <= (cur_kind == KIND_TONE) ? tone_freq : '0;
      last         <= cur_last;
    end
  end

  a_stop_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && element_kind == KIND_STOP |-> last && duration_ms == '0)
    else $error("stop element without last or with nonzero duration");

  a_freq_tone_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && element_kind != KIND_TONE |-> frequency_hz == '0)
    else $error("frequency on a non-tone element");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> element_kind == KIND_TONE || element_kind == KIND_REST ||
                  element_kind == KIND_STOP)
    else $error("invalid element kind");

  a_load_path: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_LOAD)
    else $error("output loaded outside the load step");

  a_mul_length: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD && $past(state) == ST_MUL |-> $past(mul_cnt) == '1)
    else $error("multiplier left early");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import mts_pkg::*;

  localparam logic FUNC_CHAR = 1'b0;
  localparam logic FUNC_STOP = 1'b1;
  localparam logic [CfgIndexW-1:0] REG_UNUSED = 3'd7;
  localparam logic [CfgIndexW-1:0] REG_ORDER [8] = '{
    REG_UNIT_MS, REG_TONE_FREQ, REG_DOT_UNITS, REG_DASH_UNITS,
    REG_SYM_GAP, REG_LETTER_GAP, REG_WORD_GAP, REG_UNUSED
  };
  localparam logic [CharW-1:0] SPACE_CHAR = 8'h20;
  localparam int RANDOM_PER_PHASE = 42;
  localparam int NUM_PHASES = 6;
  localparam int SETTLE_CYCLES = 80;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [DurW-1:0]  duration;
    logic [FreqW-1:0] frequency;
    logic             last;
  } element_t;

  class tone_scoreboard;
    logic [UnitMsW-1:0] unit_ms;
    logic [FreqW-1:0]   tone_hz;
    logic [UnitsW-1:0]  dot_units;
    logic [UnitsW-1:0]  dash_units;
    logic [UnitsW-1:0]  symbol_gap;
    logic [UnitsW-1:0]  letter_gap;
    logic [UnitsW-1:0]  word_gap;
    bit                 after_space;
    element_t           pending_elements[$];
    element_t           burst[12];
    int                 burst_n;
    int                 errors;
    int                 n_chars;
    int                 n_stops;
    int                 n_checked;

    function new();
      unit_ms = UNIT_MS_RESET;
      tone_hz = TONE_FREQ_RESET;
      dot_units = DOT_RESET;
      dash_units = DASH_RESET;
      symbol_gap = SYM_GAP_RESET;
      letter_gap = LETTER_GAP_RESET;
      word_gap = WORD_GAP_RESET;
      after_space = 1'b1;
      errors = 0;
      n_chars = 0;
      n_stops = 0;
      n_checked = 0;
    endfunction

    function void set_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_UNIT_MS:    unit_ms = data[UnitMsW-1:0];
        REG_TONE_FREQ:  tone_hz = data[FreqW-1:0];
        REG_DOT_UNITS:  dot_units = data[UnitsW-1:0];
        REG_DASH_UNITS: dash_units = data[UnitsW-1:0];
        REG_SYM_GAP:    symbol_gap = data[UnitsW-1:0];
        REG_LETTER_GAP: letter_gap = data[UnitsW-1:0];
        REG_WORD_GAP:   word_gap = data[UnitsW-1:0];
        default: ;
      endcase
    endfunction

    function bit is_spacing(logic [CharW-1:0] c);
      return c == SPACE_CHAR || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function logic [CharW-1:0] lower_case(logic [CharW-1:0] c);
      if ((c >= "A" && c <= "Z") || (c >= 8'hC0 && c <= 8'hDE && c != 8'hD7)) begin
        return c + 8'h20;
      end
      return c;
    endfunction

    function string marks_of(logic [CharW-1:0] c);
      case (c)
        "a": return ".-";     "b": return "-...";   "c": return "-.-.";
        "d": return "-..";    "e": return ".";      "f": return "..-.";
        "g": return "--.";    "h": return "....";   "i": return "..";
        "j": return ".---";   "k": return "-.-";    "l": return ".-..";
        "m": return "--";     "n": return "-.";     "o": return "---";
        "p": return ".--.";   "q": return "--.-";   "r": return ".-.";
        "s": return "...";    "t": return "-";      "u": return "..-";
        "v": return "...-";   "w": return ".--";    "x": return "-..-";
        "y": return "-.--";   "z": return "--..";
        8'hE4: return ".-.-";  8'hE1: return ".--.-";  8'hE5: return ".--.-";
        8'hE9: return "..-.."; 8'hF1: return "--.--";  8'hF6: return "---.";
        8'hFC: return "..--";
        "0": return "-----";  "1": return ".----";  "2": return "..---";
        "3": return "...--";  "4": return "....-";  "5": return ".....";
        "6": return "-....";  "7": return "--...";  "8": return "---..";
        "9": return "----.";
        ".": return ".-.-.-"; ",": return "--..--"; "?": return "..--..";
        "!": return "-.-.--"; ":": return "---..."; "'": return ".----.";
        "\"": return ".-..-."; "(": return "-.--."; ")": return "-.--.-";
        "=": return "-...-";  "+": return ".-.-.";  "-": return "-....-";
        "/": return "-..-.";  "&": return ".-...";  "@": return ".--.-.";
        default: return "";
      endcase
    endfunction

    function void add_element(logic [KindW-1:0] kind, logic [UnitsW-1:0] units);
      int product;
      product = int'(unit_ms) * int'(units);
      burst[burst_n].kind = kind;
      burst[burst_n].duration = (kind == KIND_STOP) ? '0 : product[DurW-1:0];
      burst[burst_n].frequency = (kind == KIND_TONE) ? tone_hz : '0;
      burst[burst_n].last = 1'b0;
      burst_n++;
    endfunction

    function void note_item(logic is_stop, logic [CharW-1:0] cp);
      string marks;
      burst_n = 0;
      if (is_stop == FUNC_STOP) begin
        n_stops++;
        add_element(KIND_STOP, '0);
      end else if (is_spacing(cp)) begin
        n_chars++;
        if (!after_space) begin
          after_space = 1'b1;
          add_element(KIND_REST, word_gap);
        end
      end else begin
        n_chars++;
        if (after_space) begin
          after_space = 1'b0;
        end else begin
          add_element(KIND_REST, letter_gap);
        end
        marks = marks_of(lower_case(cp));
        for (int i = 0; i < marks.len(); i++) begin
          if (i > 0) begin
            add_element(KIND_REST, symbol_gap);
          end
          add_element(KIND_TONE, (marks[i] == ".") ? dot_units : dash_units);
        end
      end
      for (int i = 0; i < burst_n; i++) begin
        burst[i].last = (i == burst_n - 1);
        pending_elements.push_back(burst[i]);
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_element(element_t got);
      element_t want;
      n_checked++;
      if (pending_elements.size() == 0) begin
        report_mismatch($sformatf("element kind %0d duration %0d with nothing pending",
                                  got.kind, got.duration));
        return;
      end
      want = pending_elements.pop_front();
      if (got.kind !== want.kind) begin
        report_mismatch($sformatf("kind %0d, wanted %0d", got.kind, want.kind));
      end
      if (got.duration !== want.duration) begin
        report_mismatch($sformatf("duration %0d, wanted %0d", got.duration, want.duration));
      end
      if (got.frequency !== want.frequency) begin
        report_mismatch($sformatf("frequency %0d, wanted %0d", got.frequency,
                                  want.frequency));
      end
      if (got.last !== want.last) begin
        report_mismatch($sformatf("last %0b, wanted %0b", got.last, want.last));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic                 func;
  logic [CharW-1:0]     code_point;
  logic                 out_valid;
  logic                 out_stall;
  logic [KindW-1:0]     element_kind;
  logic [DurW-1:0]      duration_ms;
  logic [FreqW-1:0]     frequency_hz;
  logic                 last;
  logic                 cfg_we;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;

  tone_scoreboard sb;
  bit             tx_quiet;
  bit             rx_quiet;
  int             stall_left;
  int             hold;
  element_t       got_elem;

  string text_chars =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?!:'\"()=+-/&@";
  logic [CharW-1:0] accented [14] = '{
    8'hE4, 8'hE1, 8'hE5, 8'hE9, 8'hF1, 8'hF6, 8'hFC,
    8'hC4, 8'hC1, 8'hC5, 8'hC9, 8'hD1, 8'hD6, 8'hDC
  };
  logic [CharW:0] directed [24] = '{
    {FUNC_CHAR, 8'h20}, {FUNC_CHAR, 8'h41}, {FUNC_CHAR, 8'h5A}, {FUNC_CHAR, 8'h3F},
    {FUNC_CHAR, 8'h09}, {FUNC_CHAR, 8'h0D}, {FUNC_CHAR, 8'h20}, {FUNC_STOP, 8'hFF},
    {FUNC_CHAR, 8'h35}, {FUNC_STOP, 8'h00}, {FUNC_CHAR, 8'hC9}, {FUNC_CHAR, 8'hD7},
    {FUNC_CHAR, 8'h85}, {FUNC_CHAR, 8'hA0}, {FUNC_CHAR, 8'hDE}, {FUNC_CHAR, 8'hDC},
    {FUNC_CHAR, 8'h00}, {FUNC_CHAR, 8'hFF}, {FUNC_CHAR, 8'h0A}, {FUNC_CHAR, 8'h7F},
    {FUNC_CHAR, 8'h2E}, {FUNC_CHAR, 8'h40}, {FUNC_CHAR, 8'h0C}, {FUNC_CHAR, 8'h0B}
  };

  morse_tone_sequencer uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .code_point   (code_point),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .element_kind (element_kind),
    .duration_ms  (duration_ms),
    .frequency_hz (frequency_hz),
    .last         (last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      got_elem.kind = element_kind;
      got_elem.duration = duration_ms;
      got_elem.frequency = frequency_hz;
      got_elem.last = last;
      sb.check_element(got_elem);
      hold = rx_quiet ? 0 : $urandom_range(7);
      stall_left <= hold;
      out_stall <= (hold != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("testbench: done, errors");
    $finish;
  end

  task automatic send_item(input logic f, input logic [CharW-1:0] cp);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    code_point <= cp;
    do @(posedge clk); while (in_stall);
    sb.note_item(f, cp);
  endtask

  task automatic wait_empty();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_elements.size() != 0);
  endtask

  // An item that produces no elements may still be in flight when the
  // last expected element has been taken, so the block is given time to settle.
  task automatic drain();
    wait_empty();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [CfgDataW-1:0] vals [7]);
    logic [CfgDataW-1:0] data;
    for (int i = 0; i < 8; i++) begin
      data = (i < 7) ? vals[i] : CfgDataW'($urandom);
      cfg_we <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_data <= data;
      @(posedge clk);
      sb.set_reg(REG_ORDER[i], data);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly real text with stops, plus some arbitrary code points.
  task automatic send_random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 6) begin
      send_item(FUNC_STOP, CharW'($urandom));
    end else if (pick < 22) begin
      send_item(FUNC_CHAR, ($urandom_range(1) == 0) ? SPACE_CHAR
                                                     : CharW'($urandom_range(8'h0D, 8'h09)));
    end else if (pick < 32) begin
      send_item(FUNC_CHAR, CharW'($urandom_range(255)));
    end else if (pick < 40) begin
      send_item(FUNC_CHAR, accented[$urandom_range(13)]);
    end else begin
      send_item(FUNC_CHAR, text_chars[$urandom_range(text_chars.len() - 1)]);
    end
  endtask

  initial begin
    logic [CfgDataW-1:0] vals [7];
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    func = FUNC_CHAR;
    code_point = '0;
    cfg_we = 1'b0;
    cfg_index = REG_UNIT_MS;
    cfg_data = '0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        drain();
        case (phase)
          1: vals = '{15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF};
          2: vals = '{15'd1, 15'd20, 15'd1, 15'd1, 15'd1, 15'd1, 15'd1};
          3: vals = '{15'd0, 15'd20000, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0};
          default: begin
            foreach (vals[i]) vals[i] = CfgDataW'($urandom);
          end
        endcase
        apply_setting(vals);
      end
      if (phase == 0) begin
        foreach (directed[i]) send_item(directed[i][CharW], directed[i][CharW-1:0]);
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 16 == 0) begin
          tx_quiet = ($urandom_range(3) == 0);
          rx_quiet = ($urandom_range(3) == 0);
        end
        if ($urandom_range(31) == 0) begin
          wait_empty();
        end
        send_random_item();
      end
    end
    drain();

    $display("Sent %0d characters and %0d end-of-message items under %0d register settings.",
             sb.n_chars, sb.n_stops, NUM_PHASES);
    $display("Checked %0d tone, rest and stop elements against the prediction.",
             sb.n_checked);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
